>>> hw/rtl/smm_pkg.sv
// smm_pkg: shared constants, register codes and types of the small matrix multiplier.
// No dependencies; imported by every RTL file of the block except smm_ram.

package smm_pkg;

   localparam int MAX_DIM   = 8;
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int ELEM_W    = 32;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int FRAC_W    = 16;
   localparam int OUT_IDX_W = 3;
   localparam int CELLS     = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CNT_W     = $clog2(CELLS + 1);
   localparam int SZ_W      = (CNT_W > 2 * CFG_W) ? CNT_W : 2 * CFG_W;
   localparam int ACC_W     = PROD_W + $clog2(MAX_DIM) + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_B = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B = 2'd3;

   localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

   typedef struct packed {
      logic [CFG_W-1:0] rows_a;
      logic [CFG_W-1:0] cols_a;
      logic [CFG_W-1:0] rows_b;
      logic [CFG_W-1:0] cols_b;
   } dims_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } mac_tag_type;

   typedef struct packed {
      logic              done;
      logic [ELEM_W-1:0] value;
      logic              sat;
   } mac_res_type;

endpackage

>>> hw/rtl/smm_ram.sv
// smm_ram: generic single-write, single-read synchronous RAM; read data is registered.
// No dependencies.

module smm_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/smm_mac.sv
// smm_mac: multiply-accumulate pipeline for one dot product, then round and saturate.
// Depends on smm_pkg.

module smm_mac
   import smm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mac_tag_type       tag,
   input  logic [ELEM_W-1:0] rd_a,
   input  logic [ELEM_W-1:0] rd_b,
   output mac_res_type       res
);

   localparam int HI_W = ACC_W - (FRAC_W + ELEM_W - 1);

   mac_tag_type              tag1_ff, tag2_ff, tag3_ff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [ACC_W-1:0]  acc_in, acc_ff;
   logic signed [ACC_W-1:0]  rnd;
   logic [HI_W-1:0]          hi_bits;
   logic                     ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   assign prod_in = $signed(rd_a) * $signed(rd_b);

   always_comb begin
      acc_in = acc_ff;
      if (tag2_ff.vld) begin
         if (tag2_ff.first) begin
            acc_in = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
         end else begin
            acc_in = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // round half up at bit FRAC_W, then clip to the signed element range
   assign rnd     = acc_ff + ACC_W'(1 << (FRAC_W - 1));
   assign hi_bits = rnd[ACC_W-1:FRAC_W+ELEM_W-1];
   assign ovf     = !((&hi_bits) || !(|hi_bits));

   always_comb begin
      res.done = tag3_ff.vld && tag3_ff.last;
      res.sat  = ovf;
      if (ovf) begin
         res.value = rnd[ACC_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
      end else begin
         res.value = rnd[FRAC_W+ELEM_W-1:FRAC_W];
      end
   end

endmodule

>>> hw/rtl/smm_ctrl.sv
// smm_ctrl: load counters, product sequencer and result register.
// Depends on smm_pkg; drives the two operand RAMs and the smm_mac pipeline.

module smm_ctrl
   import smm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dims_type             dims,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   output mem_req_type          mem_a,
   output mem_req_type          mem_b,
   output mac_tag_type          tag,
   input  mac_res_type          mac_res,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [OUT_IDX_W-1:0] rsp_out_row,
   output logic [OUT_IDX_W-1:0] rsp_out_col,
   output logic [ELEM_W-1:0]    rsp_prod_value,
   output logic                 rsp_saturated,
   output logic                 rsp_mismatch,
   output logic                 rsp_last
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_ISSUE = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_MISM  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CFG_W-1:0]     row_ff, row_in, col_ff, col_in, term_ff, term_in;
   logic [ADDR_W-1:0]    base_ff, base_in, addr_a_ff, addr_a_in, addr_b_ff, addr_b_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0] out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic [ELEM_W-1:0]    value_ff, value_in;
   logic                 sat_ff, sat_in, mism_ff, mism_in, last_ff, last_in;

   logic [SZ_W-1:0]      size_a, size_b;
   logic                 accept, load_a, load_b, full_a, full_b;
   logic                 out_free, term_last, elem_last;
   logic [CNT_W-1:0]     cnt_a_nxt, cnt_b_nxt;

   assign size_a    = SZ_W'(dims.rows_a) * SZ_W'(dims.cols_a);
   assign size_b    = SZ_W'(dims.rows_b) * SZ_W'(dims.cols_b);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign load_a    = accept && !req_func && (SZ_W'(cnt_a_ff) < size_a);
   assign load_b    = accept && req_func && (SZ_W'(cnt_b_ff) < size_b);
   assign cnt_a_nxt = cnt_a_ff + CNT_W'(load_a);
   assign cnt_b_nxt = cnt_b_ff + CNT_W'(load_b);
   assign full_a    = SZ_W'(cnt_a_nxt) >= size_a;
   assign full_b    = SZ_W'(cnt_b_nxt) >= size_b;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign term_last = term_ff == dims.cols_a - CFG_W'(1);
   assign elem_last = (row_ff == dims.rows_a - CFG_W'(1)) &&
                      (col_ff == dims.cols_b - CFG_W'(1));

   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_nxt;
      cnt_b_in     = cnt_b_nxt;
      row_in       = row_ff;
      col_in       = col_ff;
      term_in      = term_ff;
      base_in      = base_ff;
      addr_a_in    = addr_a_ff;
      addr_b_in    = addr_b_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      value_in     = value_ff;
      sat_in       = sat_ff;
      mism_in      = mism_ff;
      last_in      = last_ff;
      tag          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if ((load_a || load_b) && full_a && full_b) begin
               cnt_a_in = '0;
               cnt_b_in = '0;
               row_in   = '0;
               col_in   = '0;
               base_in  = '0;
               state_in = (dims.cols_a != dims.rows_b) ? ST_MISM : ST_START;
            end
         end
         ST_START: begin
            if (out_free) begin
               addr_a_in = base_ff;
               addr_b_in = ADDR_W'(col_ff);
               term_in   = '0;
               state_in  = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            tag.vld   = 1'b1;
            tag.first = term_ff == '0;
            tag.last  = term_last;
            addr_a_in = addr_a_ff + ADDR_W'(1);
            addr_b_in = addr_b_ff + ADDR_W'(dims.cols_b);
            term_in   = term_ff + CFG_W'(1);
            if (term_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_res.done) begin
               rsp_valid_in = 1'b1;
               out_row_in   = row_ff[OUT_IDX_W-1:0];
               out_col_in   = col_ff[OUT_IDX_W-1:0];
               value_in     = mac_res.value;
               sat_in       = mac_res.sat;
               mism_in      = 1'b0;
               last_in      = elem_last;
               if (elem_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_START;
                  if (col_ff == dims.cols_b - CFG_W'(1)) begin
                     col_in  = '0;
                     row_in  = row_ff + CFG_W'(1);
                     base_in = base_ff + ADDR_W'(dims.cols_a);
                  end else begin
                     col_in = col_ff + CFG_W'(1);
                  end
               end
            end
         end
         ST_MISM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_row_in   = '0;
               out_col_in   = '0;
               value_in     = '0;
               sat_in       = 1'b0;
               mism_in      = 1'b1;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      col_ff     <= col_in;
      term_ff    <= term_in;
      base_ff    <= base_in;
      addr_a_ff  <= addr_a_in;
      addr_b_ff  <= addr_b_in;
      out_row_ff <= out_row_in;
      out_col_ff <= out_col_in;
      value_ff   <= value_in;
      sat_ff     <= sat_in;
      mism_ff    <= mism_in;
      last_ff    <= last_in;
   end

   assign req_stall = state_ff != ST_IDLE;

   assign mem_a.we    = load_a;
   assign mem_a.waddr = cnt_a_ff[ADDR_W-1:0];
   assign mem_a.raddr = addr_a_ff;
   assign mem_b.we    = load_b;
   assign mem_b.waddr = cnt_b_ff[ADDR_W-1:0];
   assign mem_b.raddr = addr_b_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_prod_value = value_ff;
   assign rsp_saturated  = sat_ff;
   assign rsp_mismatch   = mism_ff;
   assign rsp_last       = last_ff;

endmodule

>>> hw/rtl/small_matrix_multiply_top.sv
// small_matrix_multiply_top: Q16.16 matrix multiplier, C = A * B.
// Depends on smm_pkg, smm_ram, smm_mac and smm_ctrl.
//
// Usage: set the sizes through csr_we/csr_index/csr_wdata (rows_a, cols_a,
// rows_b, cols_b, all reset to 8; 0 acts as 1, values above MAX_DIM clamp).
// Send A then B row-major on the req_ channel; req_func selects the matrix.
// A load for a matrix that is already full is dropped. Loads are taken back
// to back while req_stall is low. The load that fills both matrices starts
// the product, which leaves row-major on the rsp_ channel with rsp_last on
// the final element; a size mismatch gives one zero result with
// rsp_mismatch set. Product elements are computed one at a time by one
// shared multiply-accumulate fed from one read port per operand RAM; the
// next element is issued only after the previous result is registered.
// req_stall is high while a product or a mismatch result is in progress.
// A stalled result is held in the output register; the sequencer waits for
// it to drain before starting the next element, but loads are taken while
// a last result waits. Reset clears the load counts and rsp_valid and
// returns the sizes to 8; RAM contents are not cleared.

module small_matrix_multiply_top
   import smm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic signed [ELEM_W-1:0] req_elem_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [OUT_IDX_W-1:0]  rsp_out_row,
   output logic [OUT_IDX_W-1:0]  rsp_out_col,
   output logic signed [ELEM_W-1:0] rsp_prod_value,
   output logic                  rsp_saturated,
   output logic                  rsp_mismatch,
   output logic                  rsp_last
);

   dims_type          cfg_ff, cfg_in, dims;
   mem_req_type       mem_a, mem_b;
   mac_tag_type       tag;
   mac_res_type       mac_res;
   logic [ELEM_W-1:0] rd_a, rd_b;
   logic [ELEM_W-1:0] prod_value;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS_A: cfg_in.rows_a = csr_wdata;
            CSR_COLS_A: cfg_in.cols_a = csr_wdata;
            CSR_ROWS_B: cfg_in.rows_b = csr_wdata;
            CSR_COLS_B: cfg_in.cols_b = csr_wdata;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= {DIM_RESET, DIM_RESET, DIM_RESET, DIM_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = CFG_W'(MAX_DIM);
      end
      return r;
   endfunction

   assign dims.rows_a = eff_dim(cfg_ff.rows_a);
   assign dims.cols_a = eff_dim(cfg_ff.cols_a);
   assign dims.rows_b = eff_dim(cfg_ff.rows_b);
   assign dims.cols_b = eff_dim(cfg_ff.cols_b);

   smm_ram #(.DEPTH(CELLS), .WIDTH(ELEM_W)) u_ram_a (
      .clock (clock),
      .we    (mem_a.we),
      .waddr (mem_a.waddr),
      .wdata (req_elem_value),
      .raddr (mem_a.raddr),
      .rdata (rd_a)
   );

   smm_ram #(.DEPTH(CELLS), .WIDTH(ELEM_W)) u_ram_b (
      .clock (clock),
      .we    (mem_b.we),
      .waddr (mem_b.waddr),
      .wdata (req_elem_value),
      .raddr (mem_b.raddr),
      .rdata (rd_b)
   );

   smm_mac u_mac (
      .clock (clock),
      .reset (reset),
      .tag   (tag),
      .rd_a  (rd_a),
      .rd_b  (rd_b),
      .res   (mac_res)
   );

   smm_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .dims           (dims),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .mem_a          (mem_a),
      .mem_b          (mem_b),
      .tag            (tag),
      .mac_res        (mac_res),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_prod_value (prod_value),
      .rsp_saturated  (rsp_saturated),
      .rsp_mismatch   (rsp_mismatch),
      .rsp_last       (rsp_last)
   );

   assign rsp_prod_value = $signed(prod_value);

endmodule

>>> hw/rtl/smm_checker.sv
// smm_checker: port-level assertions for small_matrix_multiply_top, plus its bind.
// Depends on smm_pkg.

module smm_checker
   import smm_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [OUT_IDX_W-1:0] rsp_out_row,
   input logic [OUT_IDX_W-1:0] rsp_out_col,
   input logic [ELEM_W-1:0]    rsp_prod_value,
   input logic                 rsp_saturated,
   input logic                 rsp_mismatch,
   input logic                 rsp_last
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_prod_value) &&
      $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_last))
      else $error("rsp transaction changed while stalled");

   a_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set right after reset");

   // mid-product: loads are still blocked after a non-final element is taken
   a_block_mid_product: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> req_stall)
      else $error("load taken in the middle of a product");

   a_mismatch_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mismatch |->
      rsp_last && !rsp_saturated && (rsp_prod_value == '0) &&
      (rsp_out_row == '0) && (rsp_out_col == '0))
      else $error("bad mismatch result");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
      (rsp_prod_value == 32'h7FFF_FFFF) || (rsp_prod_value == 32'h8000_0000))
      else $error("saturated flag without a clipped value");

endmodule

bind small_matrix_multiply_top smm_checker u_smm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_row    (rsp_out_row),
   .rsp_out_col    (rsp_out_col),
   .rsp_prod_value (rsp_prod_value),
   .rsp_saturated  (rsp_saturated),
   .rsp_mismatch   (rsp_mismatch),
   .rsp_last       (rsp_last)
);

>>> dv/matmul_checker.sv
`timescale 1ns / 1ps
// matmul_checker: watches the csr_, req_ and rsp_ ports of small_matrix_multiply_top,
// predicts each product element and compares it with the rsp_ transactions.
// Depends on smm_pkg; also holds matmul_tb_pkg, the load codes shared with tb_top.

package matmul_tb_pkg;
   localparam logic LOAD_A = 1'b0;
   localparam logic LOAD_B = 1'b1;
endpackage

module matmul_checker
   import smm_pkg::*;
   import matmul_tb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CFG_W-1:0]         csr_wdata,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic                     req_func,
   input  logic signed [ELEM_W-1:0] req_elem_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [OUT_IDX_W-1:0]     rsp_out_row,
   input  logic [OUT_IDX_W-1:0]     rsp_out_col,
   input  logic signed [ELEM_W-1:0] rsp_prod_value,
   input  logic                     rsp_saturated,
   input  logic                     rsp_mismatch,
   input  logic                     rsp_last,
   output int                       fail_count,
   output int                       pending
);

   typedef struct packed {
      logic [OUT_IDX_W-1:0]     row;
      logic [OUT_IDX_W-1:0]     col;
      logic signed [ELEM_W-1:0] value;
      logic                     sat;
      logic                     mis;
      logic                     last;
   } prod_elem_s;

   logic signed [ELEM_W-1:0] mat_a [CELLS];
   logic signed [ELEM_W-1:0] mat_b [CELLS];
   int unsigned              loaded_a;
   int unsigned              loaded_b;
   dims_type                 dims;
   prod_elem_s               product_q [$];

   function automatic int eff_dim(input logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   task automatic predict_load(input logic func, input logic signed [ELEM_W-1:0] value);
      int                  ra, ca, rb, cb;
      int                  i, j, t;
      logic signed [63:0]  prod;
      logic signed [71:0]  acc;
      logic signed [71:0]  rnd;
      prod_elem_s          e;
      ra = eff_dim(dims.rows_a);
      ca = eff_dim(dims.cols_a);
      rb = eff_dim(dims.rows_b);
      cb = eff_dim(dims.cols_b);
      if (func == LOAD_A) begin
         if (loaded_a >= ra * ca) return;
         mat_a[loaded_a % CELLS] = value;
         loaded_a++;
      end else begin
         if (loaded_b >= rb * cb) return;
         mat_b[loaded_b % CELLS] = value;
         loaded_b++;
      end
      if (loaded_a < ra * ca || loaded_b < rb * cb) return;
      loaded_a = 0;
      loaded_b = 0;
      if (ca != rb) begin
         e = '0;
         e.mis = 1'b1;
         e.last = 1'b1;
         product_q.push_back(e);
         return;
      end
      for (i = 0; i < ra; i++) begin
         for (j = 0; j < cb; j++) begin
            acc = '0;
            for (t = 0; t < ca; t++) begin
               prod = mat_a[(i * ca + t) % CELLS] * mat_b[(t * cb + j) % CELLS];
               acc = acc + prod;
            end
            // round half up, then floor back to Q16.16
            rnd = (acc + 72'sd32768) >>> 16;
            e.row = OUT_IDX_W'(i);
            e.col = OUT_IDX_W'(j);
            e.mis = 1'b0;
            e.last = (i == ra - 1) && (j == cb - 1);
            if (rnd > 72'sd2147483647) begin
               e.value = 32'sh7FFFFFFF;
               e.sat = 1'b1;
            end else if (rnd < -72'sd2147483648) begin
               e.value = 32'sh80000000;
               e.sat = 1'b1;
            end else begin
               e.value = rnd[ELEM_W-1:0];
               e.sat = 1'b0;
            end
            product_q.push_back(e);
         end
      end
   endtask

   task automatic report(input string what, input prod_elem_s want, input prod_elem_s got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t %s: expected row %0d col %0d value %h sat %b mis %b last %b", $time,
                  what, want.row, want.col, want.value, want.sat, want.mis, want.last);
         $display("%0t %s: actual   row %0d col %0d value %h sat %b mis %b last %b", $time,
                  what, got.row, got.col, got.value, got.sat, got.mis, got.last);
      end
   endtask

   always @(posedge clock) begin
      prod_elem_s got;
      prod_elem_s want;
      if (reset) begin
         loaded_a = 0;
         loaded_b = 0;
         dims = {DIM_RESET, DIM_RESET, DIM_RESET, DIM_RESET};
         product_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_row, rsp_out_col, rsp_prod_value, rsp_saturated,
                   rsp_mismatch, rsp_last};
            if (product_q.size() == 0) begin
               report("unexpected transaction", 'x, got);
            end else begin
               want = product_q.pop_front();
               if (got !== want) report("mismatch", want, got);
            end
         end
         if (req_valid && !req_stall) predict_load(req_func, req_elem_value);
         if (csr_we) begin
            case (csr_index)
               CSR_ROWS_A: dims.rows_a = csr_wdata;
               CSR_COLS_A: dims.cols_a = csr_wdata;
               CSR_ROWS_B: dims.rows_b = csr_wdata;
               CSR_COLS_B: dims.cols_b = csr_wdata;
               default: ;
            endcase
         end
      end
      pending = product_q.size();
   end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for small_matrix_multiply_top; matmul_checker does the checking.
// Depends on smm_pkg, matmul_tb_pkg, matmul_checker and small_matrix_multiply_top.

module tb_top;
   import smm_pkg::*;
   import matmul_tb_pkg::*;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_ROWS_A;
   logic [CFG_W-1:0]         csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_func = LOAD_A;
   logic signed [ELEM_W-1:0] req_elem_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [OUT_IDX_W-1:0]     rsp_out_row;
   logic [OUT_IDX_W-1:0]     rsp_out_col;
   logic signed [ELEM_W-1:0] rsp_prod_value;
   logic                     rsp_saturated;
   logic                     rsp_mismatch;
   logic                     rsp_last;
   int                       fail_count;
   int                       pending;

   int       send_idle_pct = 7;
   int       recv_stall_pct = 67;
   int       loads_done = 0;
   dims_type cfg = {DIM_RESET, DIM_RESET, DIM_RESET, DIM_RESET};

   small_matrix_multiply_top u_top (.*);
   matmul_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   function automatic int eff_dim(input logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic logic [CFG_W-1:0] pick_dim();
      case ($urandom_range(15))
         0: return '0;
         1: return CFG_W'($urandom_range(MAX_DIM + 1, 15));
         2: return CFG_W'(MAX_DIM);
         default: return CFG_W'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic logic [ELEM_W-1:0] rand_elem();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(4))
               0: return 32'h7FFFFFFF;
               1: return 32'h80000000;
               2: return 32'h00000000;
               3: return 32'h00000001;
               default: return 32'hFFFFFFFF;
            endcase
         end
         1, 2, 3: return $urandom;
         // within +/-4.0
         default: return $urandom_range(0, (1 << 19) - 1) - (1 << 18);
      endcase
   endfunction

   task automatic send_load(input logic func, input logic [ELEM_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_elem_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_products();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_dims(input logic [CFG_W-1:0] ra, input logic [CFG_W-1:0] ca,
                             input logic [CFG_W-1:0] rb, input logic [CFG_W-1:0] cb);
      drain_products();
      csr_we <= 1'b1;
      csr_index <= CSR_ROWS_A;
      csr_wdata <= ra;
      @(posedge clock);
      csr_index <= CSR_COLS_A;
      csr_wdata <= ca;
      @(posedge clock);
      csr_index <= CSR_ROWS_B;
      csr_wdata <= rb;
      @(posedge clock);
      csr_index <= CSR_COLS_B;
      csr_wdata <= cb;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg = {ra, ca, rb, cb};
   endtask

   // A and B loads interleaved at random, with the odd load to a full matrix
   task automatic load_pair();
      int   size_a, size_b, na, nb;
      logic full_a, full_b;
      size_a = eff_dim(cfg.rows_a) * eff_dim(cfg.cols_a);
      size_b = eff_dim(cfg.rows_b) * eff_dim(cfg.cols_b);
      na = 0;
      nb = 0;
      while (na < size_a || nb < size_b) begin
         full_a = (na >= size_a);
         full_b = (nb >= size_b);
         if (full_a != full_b && $urandom_range(19) == 0) begin
            send_load(full_a ? LOAD_A : LOAD_B, rand_elem());
         end else if (!full_a && (full_b || $urandom_range(1) == 0)) begin
            send_load(LOAD_A, rand_elem());
            na++;
         end else begin
            send_load(LOAD_B, rand_elem());
            nb++;
         end
      end
      loads_done += size_a + size_b;
   endtask

   initial begin
      int               phase, goal;
      logic [CFG_W-1:0] ra, ca, rb, cb;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero sizes act as one; positive saturation
      write_dims(4'd0, 4'd0, 4'd0, 4'd0);
      send_load(LOAD_A, 32'h7FFFFFFF);
      send_load(LOAD_B, 32'h7FFFFFFF);

      // rounding, with a dropped load to the full B
      write_dims(4'd1, 4'd2, 4'd2, 4'd1);
      send_load(LOAD_A, 32'h00018000);
      send_load(LOAD_B, 32'h00000001);
      send_load(LOAD_B, 32'hFFFFFFFF);
      send_load(LOAD_B, 32'h12345678);
      send_load(LOAD_A, 32'hFFFF8000);

      // inner size mismatch
      write_dims(4'd1, 4'd2, 4'd1, 4'd1);
      send_load(LOAD_A, 32'h00010000);
      send_load(LOAD_B, 32'h00020000);
      send_load(LOAD_A, 32'hFFFF0000);

      // A shrinks under its count mid-load and counts as full
      write_dims(4'd2, 4'd2, 4'd2, 4'd1);
      send_load(LOAD_A, 32'h00010000);
      send_load(LOAD_A, 32'h00020000);
      send_load(LOAD_A, 32'h00030000);
      write_dims(4'd1, 4'd2, 4'd2, 4'd1);
      send_load(LOAD_B, 32'h00008000);
      send_load(LOAD_B, 32'hFFFE8000);

      // oversize clamps to MAX_DIM; saturation both ways
      write_dims(4'd1, 4'd1, 4'd1, 4'd15);
      send_load(LOAD_A, 32'h80000000);
      send_load(LOAD_B, 32'h7FFFFFFF);
      send_load(LOAD_B, 32'h80000000);
      send_load(LOAD_B, 32'h00000000);
      send_load(LOAD_B, 32'h00000001);
      send_load(LOAD_B, 32'hFFFFFFFF);
      send_load(LOAD_B, 32'h00010000);
      send_load(LOAD_B, 32'h00008000);
      send_load(LOAD_B, 32'hFFFF8000);

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 7;
               recv_stall_pct = 67;
            end
            1: begin
               send_idle_pct = 67;
               recv_stall_pct = 7;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         goal = loads_done + 134;
         while (loads_done < goal) begin
            if ($urandom_range(2) == 0) begin
               ra = pick_dim();
               ca = pick_dim();
               cb = pick_dim();
               rb = ($urandom_range(7) == 0) ? pick_dim() : ca;
               write_dims(ra, ca, rb, cb);
            end
            load_pair();
         end
      end

      drain_products();
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/smm_pkg.sv
hw/rtl/smm_ram.sv
hw/rtl/smm_mac.sv
hw/rtl/smm_ctrl.sv
hw/rtl/small_matrix_multiply_top.sv
hw/rtl/smm_checker.sv
dv/matmul_checker.sv
dv/tb_top.sv
